// ===== rtl/core/xsr_pkg.sv =====
// xsr_pkg: shared types and constants of the xorshift1024* ranged generator
// used by the controller, the datapath and the top level; depends on nothing
package xsr_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned WORDS   = 16;
    localparam int unsigned PTR_W   = 4;
    localparam int unsigned KIND_W  = 2;

    localparam logic [WORD_W-1:0] MULT = 64'd1181783497276652981;
    localparam int unsigned SHL  = 31;
    localparam int unsigned SHR1 = 11;
    localparam int unsigned SHR0 = 30;

    // item kinds, as carried in tuser
    localparam logic [KIND_W-1:0] KIND_RAW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RANGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FOLD  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SEED  = 2'd3;

    // result formatting
    typedef logic [1:0] t_out_sel;
    localparam t_out_sel OUT_RAW   = 2'd0;
    localparam t_out_sel OUT_FOLD  = 2'd1;
    localparam t_out_sel OUT_RANGE = 2'd2;

    // multiplier operand choice
    localparam logic MUL_DRAW  = 1'b0;  // mixed word times the odd constant
    localparam logic MUL_LIMIT = 1'b1;  // buckets times span

    // divider operand choice
    localparam logic DIV_BUCKETS = 1'b0;  // all ones over span
    localparam logic DIV_INDEX   = 1'b1;  // candidate over buckets

    typedef struct packed {
        logic     latch;
        logic     seed_wr;
        logic     rd;
        logic     mix;
        logic     mul_start;
        logic     mul_sel;
        logic     div_start;
        logic     div_sel;
        logic     ld_buckets;
        logic     ld_limit;
        logic     ld_cand;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              span_zero;
        logic              mul_done;
        logic              div_done;
        logic              reject;
        logic              out_free;
    } t_status;

endpackage

// ===== rtl/core/xorshift1024_star_ranged_rng_top.sv =====
// xorshift1024_star_ranged_rng_top: xorshift1024* generator with raw, folded
// and ranged draws; uses xsr_pkg, xsr_ctrl and xsr_dp
//
//  channel  | direction | tdata                                   | tuser
//  s_axis   | in        | range_low, range_high, seed_index,      | kind
//           |           | seed_value (200 bits, top 4 zero)       |
//  m_axis   | out       | value (64 bits)                         | -
//
// a seed write leaves the block ready again the next cycle
// a raw or folded draw steps through the state read, the mix and the multiply
// a ranged draw adds two passes through the bit-serial divider and one more pass
// through the shared multiplier; each rejected draw repeats the read, mix and multiply
// synchronous active-low reset clears the pointer and the word valid flags, so the state words read as zero
// a waiting result sits in the output register; the next item is taken meanwhile
module xorshift1024_star_ranged_rng_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input transfer
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [199:0] s_axis_tdata,  // range_low[63:0], range_high[127:64],
                                        // seed_index[131:128], seed_value[195:132]
    input  logic [1:0]   s_axis_tuser,  // kind[1:0]
    // result transfer
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata   // value[63:0]
);
    xsr_pkg::t_cmd    cmd;
    xsr_pkg::t_status status;

    // state machine: sequences the draw, divide and multiply steps
    xsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_kind   (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath: state words, arithmetic units and the output register
    xsr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (s_axis_tuser),
        .i_range_low  (s_axis_tdata[63:0]),
        .i_range_high (s_axis_tdata[127:64]),
        .i_seed_index (s_axis_tdata[131:128]),
        .i_seed_value (s_axis_tdata[195:132]),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_value      (m_axis_tdata)
    );

    // a seed write leaves the block ready for the next transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == xsr_pkg::KIND_SEED)
        |=> s_axis_tready)
        else $error("block busy after a seed write");

    // a draw keeps the block busy in the cycle after it is accepted
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != xsr_pkg::KIND_SEED)
        |=> !s_axis_tready)
        else $error("block ready right after accepting a draw");

    // a result is only loaded into a free output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending output");

    // a loaded result shows up on the output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

// ===== rtl/core/xsr_div.sv =====
// xsr_div: iterative restoring divider, one quotient bit per cycle
// uses xsr_pkg for the word width
module xsr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [xsr_pkg::WORD_W-1:0]   i_dividend,
    input  logic [xsr_pkg::WORD_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [xsr_pkg::WORD_W-1:0]   o_quotient
);
    localparam int unsigned W     = xsr_pkg::WORD_W;
    localparam int unsigned CNT_W = $clog2(W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_dvs, n_dvs;
    logic [W:0]       rem_sh;
    logic [W:0]       diff;

    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                n_rem = diff[W-1:0];
            end else begin
                n_rem = rem_sh[W-1:0];
            end
            n_quo = {r_quo[W-2:0], ~diff[W]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/xsr_mul.sv =====
// xsr_mul: low half of a 64x64 product from three 32x32 partial products
// one shared multiplier for the partial products; uses xsr_pkg for widths
module xsr_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [xsr_pkg::WORD_W-1:0]   i_a,
    input  logic [xsr_pkg::WORD_W-1:0]   i_b,
    output logic                         o_done,
    output logic [xsr_pkg::WORD_W-1:0]   o_result
);
    localparam int unsigned W = xsr_pkg::WORD_W;
    localparam int unsigned H = xsr_pkg::HALF_W;

    logic         r_busy;
    logic [1:0]   r_step;
    logic [W-1:0] r_a, r_b;
    logic [W-1:0] r_prod;
    logic [W-1:0] r_acc;
    logic [H-1:0] op_a, op_b;
    logic [W-1:0] cross_sh;

    // step 0: lo*lo, step 1: lo(a)*hi(b), step 2: hi(a)*lo(b)
    always_comb begin
        case (r_step)
            2'd0: begin
                op_a = r_a[H-1:0];
                op_b = r_b[H-1:0];
            end
            2'd1: begin
                op_a = r_a[H-1:0];
                op_b = r_b[W-1:H];
            end
            default: begin
                op_a = r_a[W-1:H];
                op_b = r_b[H-1:0];
            end
        endcase
    end

    assign cross_sh = {r_prod[H-1:0], {H{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 2'd0;
        end else if (r_busy) begin
            r_step <= r_step + 2'd1;
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            r_prod <= W'(op_a) * W'(op_b);
            case (r_step)
                2'd1:    r_acc <= r_prod;
                2'd2:    r_acc <= r_acc + cross_sh;
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_done   = r_busy && (r_step == 2'd3);
    assign o_result = r_acc + cross_sh;

endmodule

// ===== rtl/core/xsr_dp.sv =====
// xsr_dp: datapath with the sixteen state words, word pointer, mixing logic,
// range registers and the output register; uses xsr_pkg, xsr_div, xsr_mul
module xsr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  xsr_pkg::t_cmd                 i_cmd,
    output xsr_pkg::t_status              o_status,
    input  logic [xsr_pkg::KIND_W-1:0]    i_kind,
    input  logic [xsr_pkg::WORD_W-1:0]    i_range_low,
    input  logic [xsr_pkg::WORD_W-1:0]    i_range_high,
    input  logic [xsr_pkg::PTR_W-1:0]     i_seed_index,
    input  logic [xsr_pkg::WORD_W-1:0]    i_seed_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [xsr_pkg::WORD_W-1:0]    o_value
);
    localparam int unsigned W = xsr_pkg::WORD_W;
    localparam int unsigned H = xsr_pkg::HALF_W;
    localparam int unsigned N = xsr_pkg::WORDS;
    localparam int unsigned P = xsr_pkg::PTR_W;

    logic [W-1:0]              r_mem [N];
    logic [N-1:0]              r_wvalid;
    logic [P-1:0]              r_ptr;
    logic [P-1:0]              ptr_nx;
    logic [W-1:0]              r_rd0, r_rd1;
    logic                      r_v0, r_v1;
    logic [W-1:0]              s0, s1, s1x, mixed;

    logic [xsr_pkg::KIND_W-1:0] r_kind;
    logic [W-1:0]              r_lo;
    logic [W-1:0]              r_span;
    logic [W-1:0]              r_buckets;
    logic [W-1:0]              r_limit;
    logic [W-1:0]              r_cand;

    logic                      r_out_valid;
    logic [W-1:0]              r_out_value;
    logic [W-1:0]              out_nx;

    logic                      wr_en;
    logic [P-1:0]              wr_addr;
    logic [W-1:0]              wr_data;

    logic                      mul_done, div_done;
    logic [W-1:0]              mul_a, mul_b, mul_res;
    logic [W-1:0]              div_n, div_d, div_q;

    assign ptr_nx = r_ptr + 1'b1;

    // unwritten words read as zero
    assign s0    = r_v0 ? r_rd0 : '0;
    assign s1    = r_v1 ? r_rd1 : '0;
    assign s1x   = s1 ^ (s1 << xsr_pkg::SHL);
    assign mixed = s1x ^ s0 ^ (s1x >> xsr_pkg::SHR1) ^ (s0 >> xsr_pkg::SHR0);

    // single write port: seed write or generator update
    assign wr_en   = i_cmd.seed_wr || i_cmd.mix;
    assign wr_addr = i_cmd.seed_wr ? i_seed_index : ptr_nx;
    assign wr_data = i_cmd.seed_wr ? i_seed_value : mixed;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd0 <= r_mem[r_ptr];
            r_rd1 <= r_mem[ptr_nx];
            r_v0  <= r_wvalid[r_ptr];
            r_v1  <= r_wvalid[ptr_nx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_ptr    <= '0;
        end else begin
            if (wr_en) begin
                r_wvalid[wr_addr] <= 1'b1;
            end
            if (i_cmd.mix) begin
                r_ptr <= ptr_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_lo   <= i_range_low;
            r_span <= i_range_high - i_range_low + 1'b1;
        end
        if (i_cmd.ld_buckets) begin
            r_buckets <= div_q;
        end
        if (i_cmd.ld_limit) begin
            r_limit <= mul_res;
        end
        if (i_cmd.ld_cand) begin
            r_cand <= mul_res;
        end
    end

    assign mul_a = (i_cmd.mul_sel == xsr_pkg::MUL_LIMIT) ? div_q  : mixed;
    assign mul_b = (i_cmd.mul_sel == xsr_pkg::MUL_LIMIT) ? r_span : xsr_pkg::MULT;
    assign div_n = (i_cmd.div_sel == xsr_pkg::DIV_INDEX) ? r_cand    : '1;
    assign div_d = (i_cmd.div_sel == xsr_pkg::DIV_INDEX) ? r_buckets : r_span;

    xsr_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    xsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        case (i_cmd.out_sel)
            xsr_pkg::OUT_FOLD:  out_nx = {{H{1'b0}}, r_cand[W-1:H] ^ r_cand[H-1:0]};
            xsr_pkg::OUT_RANGE: out_nx = r_lo + div_q;
            default:            out_nx = r_cand;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= out_nx;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

    assign o_status.kind      = r_kind;
    assign o_status.span_zero = (r_span == '0);
    assign o_status.mul_done  = mul_done;
    assign o_status.div_done  = div_done;
    assign o_status.reject    = (r_cand >= r_limit);
    assign o_status.out_free  = !r_out_valid || i_ready;

endmodule

// ===== rtl/core/xsr_ctrl.sv =====
// xsr_ctrl: sequencing state machine for seed writes, draws and ranged draws
// uses xsr_pkg for the command and status structs and the kind codes
module xsr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [xsr_pkg::KIND_W-1:0]  i_kind,
    output logic                        o_ready,
    input  xsr_pkg::t_status            i_status,
    output xsr_pkg::t_cmd               o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPAN  = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_MIX   = 4'd5;
    localparam logic [3:0] S_MULD  = 4'd6;
    localparam logic [3:0] S_CHECK = 4'd7;
    localparam logic [3:0] S_DIV2  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;
    logic       ranged;

    // a ranged draw over the full span is a plain draw
    assign ranged = (i_status.kind == xsr_pkg::KIND_RANGE) && !i_status.span_zero;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_kind)
                        xsr_pkg::KIND_SEED:  o_cmd.seed_wr = 1'b1;
                        xsr_pkg::KIND_RANGE: n_state = S_SPAN;
                        default:             n_state = S_READ;
                    endcase
                end
            end
            S_SPAN: begin
                if (i_status.span_zero) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = xsr_pkg::DIV_BUCKETS;
                    n_state         = S_DIV1;
                end
            end
            S_DIV1: begin
                if (i_status.div_done) begin
                    o_cmd.ld_buckets = 1'b1;
                    o_cmd.mul_start  = 1'b1;
                    o_cmd.mul_sel    = xsr_pkg::MUL_LIMIT;
                    n_state          = S_MUL1;
                end
            end
            S_MUL1: begin
                if (i_status.mul_done) begin
                    o_cmd.ld_limit = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix       = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = xsr_pkg::MUL_DRAW;
                n_state         = S_MULD;
            end
            S_MULD: begin
                if (i_status.mul_done) begin
                    o_cmd.ld_cand = 1'b1;
                    n_state       = ranged ? S_CHECK : S_OUT;
                end
            end
            S_CHECK: begin
                if (i_status.reject) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = xsr_pkg::DIV_INDEX;
                    n_state         = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (ranged) begin
                    o_cmd.out_sel = xsr_pkg::OUT_RANGE;
                end else if (i_status.kind == xsr_pkg::KIND_FOLD) begin
                    o_cmd.out_sel = xsr_pkg::OUT_FOLD;
                end else begin
                    o_cmd.out_sel = xsr_pkg::OUT_RAW;
                end
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== tb/xsr_checker.sv =====
// xsr_checker: watches both stream channels of the xorshift1024* ranged generator,
// predicts every result from its own copy of the generator state and compares them
// depends on xsr_pkg for widths, constants and item kinds
module xsr_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [199:0] s_axis_tdata,   // range_low, range_high, seed_index, seed_value
    input  logic [1:0]   s_axis_tuser,   // kind
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,   // value
    output int           o_fail_count,
    output int           o_pending
);

    logic [xsr_pkg::WORD_W-1:0] gen_words [xsr_pkg::WORDS];
    logic [xsr_pkg::PTR_W-1:0]  gen_ptr;
    logic [xsr_pkg::WORD_W-1:0] value_q [$];
    logic [xsr_pkg::WORD_W-1:0] exp_value;
    logic [xsr_pkg::WORD_W-1:0] word;
    int                         fail_count = 0;

    // one generator step: mix two neighboring words, rotate the pointer, scramble
    function automatic logic [xsr_pkg::WORD_W-1:0] next_draw();
        logic [xsr_pkg::PTR_W-1:0]  p0;
        logic [xsr_pkg::PTR_W-1:0]  p1;
        logic [xsr_pkg::WORD_W-1:0] s0;
        logic [xsr_pkg::WORD_W-1:0] s1;
        logic [xsr_pkg::WORD_W-1:0] mixed;
        p0 = gen_ptr;
        p1 = p0 + 1'b1;
        s0 = gen_words[p0];
        s1 = gen_words[p1];
        s1 = s1 ^ (s1 << xsr_pkg::SHL);
        mixed = s1 ^ s0 ^ (s1 >> xsr_pkg::SHR1) ^ (s0 >> xsr_pkg::SHR0);
        gen_words[p1] = mixed;
        gen_ptr = p1;
        return mixed * xsr_pkg::MULT;
    endfunction

    // bucket rejection; a wrapped span of zero means the whole 64-bit range
    function automatic logic [xsr_pkg::WORD_W-1:0] draw_in_range(
        input logic [xsr_pkg::WORD_W-1:0] lo,
        input logic [xsr_pkg::WORD_W-1:0] hi);
        logic [xsr_pkg::WORD_W-1:0] span;
        logic [xsr_pkg::WORD_W-1:0] buckets;
        logic [xsr_pkg::WORD_W-1:0] limit;
        logic [xsr_pkg::WORD_W-1:0] cand;
        span = hi - lo + 64'd1;
        if (span == '0) begin
            return next_draw();
        end
        buckets = {xsr_pkg::WORD_W{1'b1}} / span;
        limit   = buckets * span;
        do begin
            cand = next_draw();
        end while (cand >= limit);
        return lo + cand / buckets;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < xsr_pkg::WORDS; i++) begin
                gen_words[i] = '0;
            end
            gen_ptr = '0;
            value_q.delete();
        end else begin
            // results first: nothing accepted at this edge can already be answered
            if (m_axis_tvalid && m_axis_tready) begin
                if (value_q.size() == 0) begin
                    $error("unexpected result transfer: value %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_value = value_q.pop_front();
                    if (m_axis_tdata !== exp_value) begin
                        $error("value mismatch: expected %h, actual %h",
                               exp_value, m_axis_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    xsr_pkg::KIND_RAW: begin
                        value_q.push_back(next_draw());
                    end
                    xsr_pkg::KIND_RANGE: begin
                        value_q.push_back(draw_in_range(s_axis_tdata[63:0],
                                                        s_axis_tdata[127:64]));
                    end
                    xsr_pkg::KIND_FOLD: begin
                        word = next_draw();
                        value_q.push_back({32'd0, word[63:32] ^ word[31:0]});
                    end
                    default: begin
                        gen_words[s_axis_tdata[131:128]] = s_axis_tdata[195:132];
                    end
                endcase
            end
        end
        o_pending    <= value_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/tb_xorshift1024_star_ranged_rng_top.sv =====
// tb_xorshift1024_star_ranged_rng_top: stimulus and verdict for the xorshift1024*
// ranged generator; depends on xsr_pkg, the block and xsr_checker
module tb_xorshift1024_star_ranged_rng_top;

    localparam int     CLK_PERIOD     = 8;
    localparam int     RANDOM_ITEMS   = 1200;
    localparam int     QUIET_ITEMS    = 150;     // final stretch without any idling
    localparam int     PRESSURE_AT    = 300;     // transfers before the long hold-off
    localparam int     PRESSURE_LEN   = 400;     // cycles with the result side held off
    localparam int     DRAIN_CYCLES   = 200;     // cycles of waiting after the last result
    localparam longint TIMEOUT_CYCLES = 1_500_000;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata  = '0;   // range_low, range_high, seed_index, seed_value
    logic [1:0]   s_axis_tuser  = xsr_pkg::KIND_RAW;  // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b1;
    logic [63:0]  m_axis_tdata;         // value

    int fail_count;
    int pending;
    int items_sent = 0;
    int idle_pct   = 10;                // shared idling rate of both sides, in percent

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    xorshift1024_star_ranged_rng_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    xsr_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // offer one item and return at the edge where it transfers; tvalid stays high
    // so a following item can go out back to back
    task automatic send_item(input logic [1:0]  kind,
                             input logic [63:0] lo,
                             input logic [63:0] hi,
                             input logic [3:0]  idx,
                             input logic [63:0] val);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'd0, val, idx, hi, lo};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        items_sent++;
    endtask

    // result side: short random stalls, plus one long hold-off so the block backs up
    initial begin
        bit held;
        held = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!held && items_sent >= PRESSURE_AT) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_LEN) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [1:0]  kind;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] tmp;
        logic [3:0]  idx;
        logic [63:0] val;
        int          pick;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero state after reset: every draw is zero, a ranged draw gives its low bound
        send_item(xsr_pkg::KIND_RAW,   '0, '0, 4'd0, '0);
        send_item(xsr_pkg::KIND_FOLD,  '0, '0, 4'd0, '0);
        send_item(xsr_pkg::KIND_RANGE, 64'd5, 64'd100, 4'd0, '0);
        send_item(xsr_pkg::KIND_RANGE, '0, '1, 4'd0, '0);

        // seed both end words plus a couple in between, all-ones and zero values
        send_item(xsr_pkg::KIND_SEED, '0, '0, 4'd0,  '1);
        send_item(xsr_pkg::KIND_SEED, '0, '0, 4'd1,  64'h0123_4567_89ab_cdef);
        send_item(xsr_pkg::KIND_SEED, '0, '0, 4'd15, rand_word());
        send_item(xsr_pkg::KIND_SEED, '0, '0, 4'd8,  '0);

        send_item(xsr_pkg::KIND_RAW,   '0, '0, 4'd0, '0);
        send_item(xsr_pkg::KIND_FOLD,  '1, '1, 4'd15, '1);
        // full span wraps to zero: plain draw, no division
        send_item(xsr_pkg::KIND_RANGE, '0, '1, 4'd0, '0);
        // reversed bounds, span and sum both wrap
        send_item(xsr_pkg::KIND_RANGE, 64'hffff_ffff_0000_0000, 64'h10, 4'd0, '0);
        // single-value ranges at both ends, then a two-value range
        send_item(xsr_pkg::KIND_RANGE, '0, '0, 4'd0, '0);
        send_item(xsr_pkg::KIND_RANGE, '1, '1, 4'd0, '0);
        send_item(xsr_pkg::KIND_RANGE, '0, 64'd1, 4'd0, '0);
        // just over and exactly half the word range: one bucket, about half the draws rejected
        send_item(xsr_pkg::KIND_RANGE, '0, 64'h8000_0000_0000_0000, 4'd0, '0);
        send_item(xsr_pkg::KIND_RANGE, 64'h8000_0000_0000_0000, '1, 4'd0, '0);
        // span of all ones: only the all-ones draw is rejected
        send_item(xsr_pkg::KIND_RANGE, 64'd1, '1, 4'd0, '0);
        send_item(xsr_pkg::KIND_RAW,   '0, '0, 4'd0, '0);
        send_item(xsr_pkg::KIND_FOLD,  '0, '0, 4'd0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // idling rate changes every hundred items, none in the final stretch
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
                idle_pct = 0;
            end else if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            pick = $urandom_range(0, 99);
            lo   = rand_word();
            hi   = rand_word();
            idx  = $urandom_range(0, 15);
            val  = rand_word();
            if (pick < 15) begin
                kind = xsr_pkg::KIND_SEED;
                case ($urandom_range(0, 7))
                    0:       val = '0;
                    1:       val = '1;
                    default: ;
                endcase
            end else if (pick < 40) begin
                kind = xsr_pkg::KIND_RAW;
            end else if (pick < 62) begin
                kind = xsr_pkg::KIND_FOLD;
            end else begin
                kind = xsr_pkg::KIND_RANGE;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: hi = lo + $urandom_range(0, 1000);
                    4, 5:       hi = lo + (rand_word() >> $urandom_range(1, 63));
                    6: begin
                        lo = '0;
                        hi = '1;
                    end
                    7: begin
                        // force reversed bounds
                        if (lo < hi) begin
                            tmp = lo;
                            lo  = hi;
                            hi  = tmp;
                        end
                    end
                    default: ;
                endcase
            end
            send_item(kind, lo, hi, idx, val);
        end
        s_axis_tvalid <= 1'b0;

        // let the pending count take in the last accepted item before polling it
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
